FILE: hw/rtl/lidar_emergency_brake_monitor_core_assert.svh
// Assertion macros used by the checker file.
`ifndef LIDAR_EMERGENCY_BRAKE_MONITOR_CORE_ASSERT_SVH
`define LIDAR_EMERGENCY_BRAKE_MONITOR_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LEBM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define LEBM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/lebm_pkg.sv
package lebm_pkg;

  // Sine table geometry
  localparam int TRIG_TABLE_DEPTH = 256;
  localparam int IDX_W = $clog2(TRIG_TABLE_DEPTH + 1);
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  // Decision constants
  localparam logic [16:0] LATERAL_MARGIN_MM = 17'd100;
  localparam logic signed [15:0] TTC_MIN_SPEED = 16'sd50;
  localparam int DIV_BITS = 26;
  localparam int CNT_W = $clog2(DIV_BITS);

  // Item kinds
  localparam logic OP_VEL = 1'b0;
  localparam logic OP_BEAM = 1'b1;

  // Reason codes
  localparam logic [1:0] REASON_SAFE = 2'd0;
  localparam logic [1:0] REASON_ZONE = 2'd1;
  localparam logic [1:0] REASON_TTC = 2'd2;

  // Register indexes
  localparam logic [2:0] REG_TTC_LIMIT = 3'd0;
  localparam logic [2:0] REG_STOP_DIST = 3'd1;
  localparam logic [2:0] REG_BRAKE_DIST = 3'd2;
  localparam logic [2:0] REG_HALF_SPAN = 3'd3;
  localparam logic [2:0] REG_HALF_WIDTH = 3'd4;
  localparam logic [2:0] REG_RANGE_MIN = 3'd5;
  localparam logic [2:0] REG_RANGE_MAX = 3'd6;

  typedef struct packed {
    logic [15:0] ttc_limit_ms;
    logic [15:0] stop_distance_mm;
    logic [15:0] braking_distance_mm;
    logic [14:0] half_span_angle;
    logic [15:0] half_width_mm;
    logic [15:0] range_min_mm;
    logic [15:0] range_max_mm;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic load_in;
    logic look;
    logic mult;
    logic upd;
    logic dec1;
    logic dec2;
    logic div_step;
    logic emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last;
    logic need_div;
    logic div_done;
    logic out_free;
  } sts_t;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_LOOK = 8'b0000_0010,
    S_MULT = 8'b0000_0100,
    S_UPD  = 8'b0000_1000,
    S_DEC1 = 8'b0001_0000,
    S_DEC2 = 8'b0010_0000,
    S_DIV  = 8'b0100_0000,
    S_EMIT = 8'b1000_0000
  } state_t;

  typedef logic [15:0] sine_tab_t [TRIG_TABLE_DEPTH+1];

  // Shift-subtract quotient, used only while building the table
  function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = 0;
    rem = 0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Q15 quarter-wave sine, Taylor series in Q30, rounded to nearest
  function automatic sine_tab_t build_sine();
    sine_tab_t tab;
    longint unsigned x;
    longint unsigned t;
    longint unsigned q;
    longint s;
    for (int k = 0; k <= TRIG_TABLE_DEPTH; k++) begin
      x = (PI_Q30 * longint'(k)) / (2 * TRIG_TABLE_DEPTH);
      t = x;
      s = longint'(x);
      for (int n = 1; n <= 6; n++) begin
        t = (t * x) >> 30;
        t = (t * x) >> 30;
        t = udiv64(t, 64'((2 * n) * (2 * n + 1)));
        if (n % 2 == 1) s = s - longint'(t);
        else s = s + longint'(t);
      end
      if (s < 0) s = 0;
      q = (longint'(s) + 64'd16384) >> 15;
      if (q > 64'd32768) q = 64'd32768;
      tab[k] = q[15:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

endpackage

FILE: hw/rtl/lidar_emergency_brake_monitor_core.sv
// Velocity item: latched, then written to the output register once free; next item taken after.
// Beam item, not last: index, sine lookup, two multiplies, corridor update.
// Last beam: the same, then DEC1 and DEC2, and when the time to collision is computed a 26-step
// restoring divider before the output. The output register lets the next item in.
// Reset (rst_n low, synchronous): registers to defaults, corridor empty, braking off.
module lidar_emergency_brake_monitor_core import lebm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // forward_speed[15:0], range_mm[31:16], range_valid[32], beam_angle[48:33]
  input  logic [55:0] in_tdata,
  // op
  input  logic        in_tuser,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // command_valid[0], safe_speed[16:1], engaged[17], ttc_ms[34:18],
  // ahead_distance_mm[51:35], closing_speed[67:52], reason_code[69:68]
  output logic [71:0] out_tdata,
  // kind
  output logic        out_tuser,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;
  logic [69:0] ofields;

  assign cfg_pready = 1'b1;
  assign out_tdata = {2'b00, ofields};

  lebm_regs u_regs (
    .clk(clk), .rst_n(rst_n), .psel(cfg_psel), .penable(cfg_penable),
    .pwrite(cfg_pwrite), .paddr(cfg_paddr), .pwdata(cfg_pwdata),
    .prdata(cfg_prdata), .cfg(cfg)
  );

  lebm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_op(in_tuser),
    .in_ready(in_tready), .sts(sts), .cmd(cmd)
  );

  lebm_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cfg(cfg), .cmd(cmd), .sts(sts),
    .in_op(in_tuser), .in_last(in_tlast), .in_fields(in_tdata[48:0]),
    .out_ready(out_tready), .out_valid(out_tvalid), .out_kind(out_tuser),
    .out_fields(ofields)
  );

endmodule

FILE: hw/rtl/lebm_regs.sv
module lebm_regs import lebm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output cfg_t        cfg
);

  cfg_t cfg_r;
  logic wr;

  assign wr = psel & penable & pwrite;
  assign cfg = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ttc_limit_ms <= 16'd1200;
      cfg_r.stop_distance_mm <= 16'd600;
      cfg_r.braking_distance_mm <= 16'd400;
      cfg_r.half_span_angle <= 15'd5461;
      cfg_r.half_width_mm <= 16'd300;
      cfg_r.range_min_mm <= 16'd0;
      cfg_r.range_max_mm <= 16'hFFFF;
    end else if (wr) begin
      unique case (paddr[4:2])
        REG_TTC_LIMIT:  cfg_r.ttc_limit_ms <= pwdata[15:0];
        REG_STOP_DIST:  cfg_r.stop_distance_mm <= pwdata[15:0];
        REG_BRAKE_DIST: cfg_r.braking_distance_mm <= pwdata[15:0];
        REG_HALF_SPAN:  cfg_r.half_span_angle <= pwdata[14:0];
        REG_HALF_WIDTH: cfg_r.half_width_mm <= pwdata[15:0];
        REG_RANGE_MIN:  cfg_r.range_min_mm <= pwdata[15:0];
        REG_RANGE_MAX:  cfg_r.range_max_mm <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (paddr[4:2])
      REG_TTC_LIMIT:  prdata = {16'd0, cfg_r.ttc_limit_ms};
      REG_STOP_DIST:  prdata = {16'd0, cfg_r.stop_distance_mm};
      REG_BRAKE_DIST: prdata = {16'd0, cfg_r.braking_distance_mm};
      REG_HALF_SPAN:  prdata = {17'd0, cfg_r.half_span_angle};
      REG_HALF_WIDTH: prdata = {16'd0, cfg_r.half_width_mm};
      REG_RANGE_MIN:  prdata = {16'd0, cfg_r.range_min_mm};
      REG_RANGE_MAX:  prdata = {16'd0, cfg_r.range_max_mm};
      default:        prdata = 32'd0;
    endcase
  end

endmodule

FILE: hw/rtl/lebm_ctrl.sv
module lebm_ctrl import lebm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_op,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // sequencing
  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt = (in_op == OP_BEAM) ? S_LOOK : S_EMIT;
        end
      end
      S_LOOK: begin
        cmd.look = 1'b1;
        state_nxt = S_MULT;
      end
      S_MULT: begin
        cmd.mult = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd = 1'b1;
        state_nxt = sts.last ? S_DEC1 : S_IDLE;
      end
      S_DEC1: begin
        cmd.dec1 = 1'b1;
        state_nxt = S_DEC2;
      end
      S_DEC2: begin
        cmd.dec2 = 1'b1;
        state_nxt = sts.need_div ? S_DIV : S_EMIT;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

FILE: hw/rtl/lebm_dp.sv
module lebm_dp import lebm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic        in_op,
  input  logic        in_last,
  input  logic [48:0] in_fields,
  input  logic        out_ready,
  output logic        out_valid,
  output logic        out_kind,
  output logic [69:0] out_fields
);

  // latched input item
  logic        op_r, last_r, vld_r;
  logic [15:0] rng_r, ang_r;

  // beam pipeline
  logic        pre_ok_r, back_r;
  logic [15:0] sin_r, cos_r;
  logic [16:0] lat_r;
  logic [15:0] proj_r;

  // scan state
  logic [15:0] cmin_r;
  logic        seen_r;
  logic [15:0] speed_r;
  logic        brake_r;

  // decision
  logic              run_r, r1_r, r2_r, need_r;
  logic [25:0]       m1000_r, brk1000_r;
  logic [30:0]       prod_r;
  logic [25:0]       quo_r;
  logic [16:0]       rem_r;
  logic [CNT_W-1:0]  cnt_r;

  // output register
  logic        ovld_r, okind_r;
  logic [69:0] odata_r;

  // beam angle fold and table index
  logic [15:0] a_abs;
  logic        back_w;
  logic [14:0] q_w;
  logic [31:0] idx_full;
  logic [IDX_W-1:0] idx;
  logic [31:0] lat_prod, proj_prod;
  logic [16:0] rem_sh;
  logic        vpos;
  logic        engage;
  logic [1:0]  reason;
  logic [16:0] ttc_w;
  logic [15:0] safe_w;

  assign a_abs = ang_r[15] ? (16'd0 - ang_r) : ang_r;
  assign back_w = a_abs > 16'd16384;
  assign q_w = back_w ? 15'(17'd32768 - {1'b0, a_abs}) : a_abs[14:0];
  assign idx_full = (32'(q_w) * 32'(TRIG_TABLE_DEPTH) + 32'd8192) >> 14;
  assign idx = (idx_full > 32'(TRIG_TABLE_DEPTH)) ? IDX_W'(TRIG_TABLE_DEPTH)
                                                   : idx_full[IDX_W-1:0];
  assign lat_prod = 32'(rng_r) * 32'(sin_r);
  assign proj_prod = 32'(rng_r) * 32'(cos_r);
  assign rem_sh = {rem_r[15:0], quo_r[DIV_BITS-1]};
  assign vpos = !speed_r[15] && (speed_r != 16'd0);

  assign sts.last = last_r;
  assign sts.need_div = need_r;
  assign sts.div_done = (cnt_r == CNT_W'(DIV_BITS - 1));
  assign sts.out_free = !ovld_r || out_ready;

  // status outcome
  always_comb begin
    engage = run_r && (r1_r || (need_r && r2_r));
    if (run_r && r1_r) reason = REASON_ZONE;
    else if (need_r && r2_r) reason = REASON_TTC;
    else reason = REASON_SAFE;
    if (!need_r) ttc_w = '1;
    else if (quo_r > 26'd65535) ttc_w = 17'd65535;
    else ttc_w = {1'b0, quo_r[15:0]};
    if (op_r == OP_VEL) safe_w = (brake_r && vpos) ? 16'd0 : speed_r;
    else safe_w = (engage && vpos) ? 16'd0 : speed_r;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmin_r <= 16'hFFFF;
      seen_r <= 1'b0;
      speed_r <= 16'd0;
      brake_r <= 1'b0;
      ovld_r <= 1'b0;
    end else begin
      if (cmd.load_in && in_op == OP_VEL) speed_r <= in_fields[15:0];
      if (cmd.upd && pre_ok_r && lat_r < ({1'b0, cfg.half_width_mm} + LATERAL_MARGIN_MM)) begin
        if (!seen_r || proj_r < cmin_r) begin
          cmin_r <= proj_r;
          seen_r <= 1'b1;
        end
      end
      if (cmd.emit) begin
        ovld_r <= 1'b1;
        if (op_r == OP_BEAM) begin
          brake_r <= engage;
          cmin_r <= 16'hFFFF;
          seen_r <= 1'b0;
        end
      end else if (ovld_r && out_ready) begin
        ovld_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r <= in_op;
      last_r <= in_last;
      rng_r <= in_fields[31:16];
      vld_r <= in_fields[32];
      ang_r <= in_fields[48:33];
    end
    if (cmd.look) begin
      pre_ok_r <= vld_r && rng_r >= cfg.range_min_mm && rng_r <= cfg.range_max_mm
                  && a_abs < {1'b0, cfg.half_span_angle};
      back_r <= back_w;
      sin_r <= SINE_TAB[idx];
      cos_r <= SINE_TAB[IDX_W'(TRIG_TABLE_DEPTH) - idx];
    end
    if (cmd.mult) begin
      lat_r <= lat_prod[31:15];
      proj_r <= back_r ? 16'd0 : ((lat_prod[31] | proj_prod[31]) & proj_prod[31]
                                   ? 16'hFFFF : proj_prod[30:15]);
    end
    if (cmd.dec1) begin
      run_r <= seen_r && cmin_r < cfg.range_max_mm && vpos;
      r1_r <= {1'b0, cmin_r} <= (17'(cfg.stop_distance_mm) + 17'(cfg.braking_distance_mm));
      need_r <= seen_r && cmin_r < cfg.range_max_mm && vpos
                && !({1'b0, cmin_r} <= (17'(cfg.stop_distance_mm)
                                        + 17'(cfg.braking_distance_mm)))
                && ($signed(speed_r) > TTC_MIN_SPEED);
      m1000_r <= 26'(cmin_r) * 26'd1000;
      brk1000_r <= 26'(cfg.braking_distance_mm) * 26'd1000;
      prod_r <= 31'(cfg.ttc_limit_ms) * 31'(speed_r[14:0]);
    end
    if (cmd.dec2) begin
      r2_r <= 32'(m1000_r) <= (32'(prod_r) + 32'(brk1000_r));
      quo_r <= m1000_r;
      rem_r <= 17'd0;
      cnt_r <= '0;
    end
    if (cmd.div_step) begin
      cnt_r <= cnt_r + CNT_W'(1);
      if (rem_sh >= {2'b00, speed_r[14:0]}) begin
        rem_r <= rem_sh - {2'b00, speed_r[14:0]};
        quo_r <= {quo_r[DIV_BITS-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        quo_r <= {quo_r[DIV_BITS-2:0], 1'b0};
      end
    end
    if (cmd.emit) begin
      okind_r <= op_r;
      if (op_r == OP_VEL) begin
        odata_r <= {REASON_SAFE, speed_r, 17'h1FFFF, 17'h1FFFF, brake_r, safe_w, 1'b1};
      end else begin
        odata_r <= {reason, speed_r, (seen_r ? {1'b0, cmin_r} : 17'h1FFFF), ttc_w,
                    engage, safe_w, engage};
      end
    end
  end

  assign out_valid = ovld_r;
  assign out_kind = okind_r;
  assign out_fields = odata_r;

endmodule

FILE: hw/rtl/lebm_checker.sv
`include "lidar_emergency_brake_monitor_core_assert.svh"

module lebm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [55:0] in_tdata,
  input logic        in_tuser,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic        out_tuser,
  input logic        cfg_psel,
  input logic        cfg_penable,
  input logic        cfg_pwrite,
  input logic [4:0]  cfg_paddr,
  input logic [31:0] cfg_pwdata,
  input logic [31:0] cfg_prdata,
  input logic        cfg_pready
);

  // stalled result holds
  `LEBM_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")
  // velocity results carry no time to collision and a safe reason
  `LEBM_ASSERT_SAME(a_vel_fields, out_tvalid && !out_tuser, out_tdata[69:68] == 2'd0 && out_tdata[34:18] == 17'h1FFFF && out_tdata[0], "bad velocity result")
  // status: command flag follows engagement
  `LEBM_ASSERT_SAME(a_stat_cmd, out_tvalid && out_tuser, out_tdata[0] == out_tdata[17], "command flag differs from engaged")
  // status: a nonzero reason exactly when engaged
  `LEBM_ASSERT_SAME(a_stat_reason, out_tvalid && out_tuser, (out_tdata[69:68] != 2'd0) == out_tdata[17], "reason and engaged disagree")

endmodule

bind lidar_emergency_brake_monitor_core lebm_checker u_lebm_checker (.*);
